[rtl/core/greedy_vertex_coloring_core_assert.svh]
// Assertion macros for the greedy vertex coloring core.
// Used by the top level only; expects signals named clk and rst in scope.
`ifndef GREEDY_VERTEX_COLORING_CORE_ASSERT_SVH
`define GREEDY_VERTEX_COLORING_CORE_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define GVC_ASSERT_NOW(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define GVC_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

[rtl/core/gvc_pkg.sv]
// Shared types, sizes and helper functions of the greedy vertex coloring core.
// No dependencies; imported by every module of the core.
`default_nettype none

package gvc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_COLORS   = 64;

  localparam int VIDX_W  = 10;   // vertex / neighbor index field
  localparam int COLOR_W = 6;    // color field
  localparam int COUNT_W = 11;   // vertex_count register

  localparam int IQ_DEPTH = 4;
  localparam int IQ_PTR_W = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W = $clog2(IQ_DEPTH + 1);

  localparam int RQ_DEPTH = 2;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef logic [MAX_COLORS-1:0] mask_t;

  typedef struct packed {
    logic [VIDX_W-1:0] neighbor;
    logic              has_neighbor;
    logic              row_last;
  } item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]  vertex;
    logic [COLOR_W-1:0] color;
    logic               color_overflow;
    logic               index_error;
    logic               matrix_done;
  } result_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic [VIDX_W-1:0] neighbor;
    logic              upd;        // valid, in-range neighbor: set its mask bit
    logic              err;        // neighbor given but out of range
    logic              row_start;  // first item of a row
    logic              row_last;
  } op_t;

  typedef struct packed {
    logic clearing;
    logic row_open;
  } back_status_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               overflow;
  } color_pick_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_UPDATE
  } back_state_t;

  // Clamp the register into 1..MAX_VERTICES.
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = COUNT_W'(1);
    end else if (v > COUNT_W'(MAX_VERTICES)) begin
      r = COUNT_W'(MAX_VERTICES);
    end
    return r;
  endfunction

  // Lowest clear bit; saturate and flag when all bits are set.
  function automatic color_pick_t first_free(input mask_t m);
    color_pick_t p;
    p.color    = COLOR_W'(MAX_COLORS - 1);
    p.overflow = 1'b1;
    for (int i = MAX_COLORS - 1; i >= 0; i--) begin
      if (!m[i]) begin
        p.color    = COLOR_W'(i);
        p.overflow = 1'b0;
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gvc_front.sv]
// Front end: accepts input items, classifies them, and queues them for the back end.
// Depends on gvc_pkg.
`default_nettype none

module gvc_front (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  output logic                         full,
  input  gvc_pkg::item_t               item,
  input  wire [gvc_pkg::COUNT_W-1:0]   count,
  output logic                         op_valid,
  input  wire                          op_ready,
  output gvc_pkg::op_t                 op
);
  import gvc_pkg::*;

  op_t                store [IQ_DEPTH];
  logic [IQ_PTR_W-1:0] wr_ptr;
  logic [IQ_PTR_W-1:0] rd_ptr;
  logic [IQ_CNT_W-1:0] fill;
  logic                start_pending;
  op_t                 op_in;
  logic                in_range;
  logic                do_push;
  logic                do_pop;

  assign full     = (fill == IQ_CNT_W'(IQ_DEPTH));
  assign op_valid = (fill != '0);
  assign op       = store[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = op_valid && op_ready;

  always_comb begin
    in_range        = {1'b0, item.neighbor} < count;
    op_in.neighbor  = item.neighbor;
    op_in.upd       = item.has_neighbor && in_range;
    op_in.err       = item.has_neighbor && !in_range;
    op_in.row_start = start_pending;
    op_in.row_last  = item.row_last;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      fill          <= '0;
      start_pending <= 1'b1;
    end else begin
      if (do_push) begin
        wr_ptr        <= wr_ptr + IQ_PTR_W'(1);
        start_pending <= item.row_last;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + IQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + IQ_CNT_W'(1);
      end else if (!do_push && do_pop) begin
        fill <= fill - IQ_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/gvc_back.sv]
// Back end: mask memory, color selection, neighbor mask updates and clearing sweep.
// Depends on gvc_pkg.
`default_nettype none

module gvc_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire [gvc_pkg::COUNT_W-1:0]   count,
  input  wire                          op_valid,
  output logic                         op_ready,
  input  gvc_pkg::op_t                 op,
  output logic                         res_push,
  input  wire                          res_full,
  output gvc_pkg::result_t             res_data,
  output gvc_pkg::back_status_t        status
);
  import gvc_pkg::*;

  mask_t               masks [MAX_VERTICES];
  back_state_t         state;
  back_state_t         state_next;
  logic [VIDX_W-1:0]   clr_addr;
  logic [VIDX_W-1:0]   vertex_counter;
  logic [COLOR_W-1:0]  cur_color;
  logic                row_err;
  logic                row_ovf;
  logic                row_open;
  op_t                 cur;
  mask_t               rd_nb;
  mask_t               rd_own;

  logic                fetch;
  logic                mem_we;
  logic [VIDX_W-1:0]   mem_waddr;
  mask_t               mem_wdata;
  color_pick_t         pick;
  logic [COLOR_W-1:0]  color;
  logic                ovf;
  logic                err;
  logic                done;

  assign status = {(state == ST_CLEAR), row_open};

  always_comb begin
    pick  = first_free(rd_own);
    color = cur.row_start ? pick.color : cur_color;
    ovf   = cur.row_start ? pick.overflow : row_ovf;
    err   = (cur.row_start ? 1'b0 : row_err) | cur.err;
    done  = {1'b0, vertex_counter} >= (count - COUNT_W'(1));

    state_next = state;
    op_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cur.neighbor;
    mem_wdata  = rd_nb | (mask_t'(1) << color);
    res_push   = 1'b0;

    res_data.vertex         = vertex_counter;
    res_data.color          = color;
    res_data.color_overflow = ovf;
    res_data.index_error    = err;
    res_data.matrix_done    = done;

    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == VIDX_W'(MAX_VERTICES - 1)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        // hold a row end until its result has a slot
        op_ready = !op.row_last || !res_full;
        if (op_valid && op_ready) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_we = cur.upd;
        if (cur.row_last) begin
          res_push   = 1'b1;
          state_next = done ? ST_CLEAR : ST_FETCH;
        end else begin
          state_next = ST_FETCH;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign fetch = (state == ST_FETCH) && op_valid && op_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      masks[mem_waddr] <= mem_wdata;
    end
    if (fetch) begin
      rd_nb  <= masks[op.neighbor];
      rd_own <= masks[vertex_counter];
      cur    <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      vertex_counter <= '0;
      cur_color      <= '0;
      row_err        <= 1'b0;
      row_ovf        <= 1'b0;
      row_open       <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + VIDX_W'(1);
      end
      if (state == ST_UPDATE) begin
        cur_color <= color;
        row_ovf   <= ovf;
        row_err   <= err;
        row_open  <= !cur.row_last;
        if (cur.row_last) begin
          if (done) begin
            vertex_counter <= '0;
            clr_addr       <= '0;
          end else begin
            vertex_counter <= vertex_counter + VIDX_W'(1);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/gvc_result_queue.sv]
// Result queue: holds finished results until the consumer pops them.
// Depends on gvc_pkg.
`default_nettype none

module gvc_result_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 wr_en,
  input  gvc_pkg::result_t    wr_data,
  output logic                full,
  input  wire                 pop,
  output logic                empty,
  output gvc_pkg::result_t    result
);
  import gvc_pkg::*;

  result_t             store [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr;
  logic [RQ_PTR_W-1:0] rd_ptr;
  logic [RQ_CNT_W-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign full    = (fill == RQ_CNT_W'(RQ_DEPTH));
  assign empty   = (fill == '0);
  assign result  = store[rd_ptr];
  assign do_push = wr_en && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + RQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + RQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + RQ_CNT_W'(1);
      end else if (!do_push && do_pop) begin
        fill <= fill - RQ_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/greedy_vertex_coloring_core.sv]
// Top level of the greedy vertex coloring core: front end, back end, result queue.
// Depends on gvc_pkg, gvc_front, gvc_back, gvc_result_queue and the assertion header.
`default_nettype none
`include "greedy_vertex_coloring_core_assert.svh"

// Greedy sequential coloring of a sparse symmetric pattern. Rows arrive in
// vertex order as runs of neighbor items, the last one marked row_last; each
// completed row pops out one result with the vertex, its color (lowest color
// absent from its forbidden mask), and overflow / index-error / matrix-done
// flags. Each item passes through the back-end states ST_FETCH, which reads the
// 1024 x 64 mask memory (neighbor entry and the vertex's own entry on two read
// ports), and ST_UPDATE, which picks the color and writes the neighbor entry
// back through the single write port. No new item is taken until ST_UPDATE is
// done with the last one; a 4-entry input queue keeps push open while the back
// end works, and a 2-entry result queue lets the back end continue while a
// result waits for pop. After reset, and after the result for the final vertex,
// the back end clears the mask memory one entry per cycle; items are still taken
// into the input queue until it fills, and vertex_count writes are always
// ready. Write vertex_count only while no transaction is in flight; values
// of 0 behave as 1 and values above 1024 as 1024.
module greedy_vertex_coloring_core (
  input  wire                          clk,
  input  wire                          rst,
  // item side
  input  wire                          push,
  output logic                         full,
  input  gvc_pkg::item_t               item,
  // result side
  input  wire                          pop,
  output logic                         empty,
  output gvc_pkg::result_t             result,
  // vertex_count write channel
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [gvc_pkg::COUNT_W-1:0]   cfg_data
);
  import gvc_pkg::*;

  logic [COUNT_W-1:0] vertex_count;
  logic [COUNT_W-1:0] count;
  logic               op_valid;
  logic               op_ready;
  op_t                op;
  logic               res_push;
  logic               res_full;
  result_t            res_data;
  back_status_t       status;

  // Register write transaction: always ready, value taken as is and clamped on use.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_W'(MAX_VERTICES);
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  assign count = eff_count(vertex_count);

  // Front end: range-check neighbors, mark row starts, queue the items.
  gvc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .count    (count),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op)
  );

  // Back end: pick colors, update neighbor masks, sweep the store clear.
  gvc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .count    (count),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .op       (op),
    .res_push (res_push),
    .res_full (res_full),
    .res_data (res_data),
    .status   (status)
  );

  // Result queue: hold finished results for the consumer.
  gvc_result_queue u_result_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // The back end only emits a result when the queue has room.
  `GVC_ASSERT_NOW(a_res_room, res_push, !res_full, "result pushed into full queue")
  // No item may leave the front end during the clearing sweep.
  `GVC_ASSERT_NOW(a_no_op_clear, op_valid && op_ready, !status.clearing, "item taken while clearing")
  // Front-end row tracking must agree with the back end's open-row state.
  `GVC_ASSERT_NOW(a_row_sync, op_valid && op_ready, op.row_start == !status.row_open, "row start mismatch")
  // The final vertex's result must start the clearing sweep.
  `GVC_ASSERT_NEXT(a_done_clear, res_push && res_data.matrix_done, status.clearing, "no sweep after final vertex")

endmodule

`default_nettype wire

[sim/tb_greedy_vertex_coloring_core.sv]
// Self-checking testbench for greedy_vertex_coloring_core: directed rows, a color
// overflow clique, random row streams and a long result hold-off.
// Depends on gvc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_greedy_vertex_coloring_core;
  import gvc_pkg::*;

  // Clearing pass plus queue depth, with margin.
  localparam int SETTLE_CYCLES = 1100;
  localparam int TAIL_CYCLES   = 1100;
  localparam int HOLD_CYCLES   = 400;
  // Longest legal quiet stretch is a clearing pass or a settle pause; allow several.
  localparam int STALL_LIMIT   = 6000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  item_t                item      = '0;
  logic                 pop       = 1'b0;
  logic                 empty;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data  = '0;

  // Traffic shaping, set by the test tasks.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  // Vertex count in force, as the stimulus generator sees it.
  int cur_count = MAX_VERTICES;

  // Coloring predictor state.
  mask_t              forbid_mask [MAX_VERTICES];
  int                 vtx_ctr;
  logic [COLOR_W-1:0] cur_color;
  logic               row_open;
  logic               row_err;
  logic               row_ovf;
  logic [COUNT_W-1:0] vcount_reg;

  result_t color_expect_q [$];
  int      fail_count   = 0;
  int      stall_cycles = 0;

  always #2 clk = ~clk;

  greedy_vertex_coloring_core u_top (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .pop       (pop),
    .empty     (empty),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Map the raw register onto 1..MAX_VERTICES.
  function automatic int clamp_count(input logic [COUNT_W-1:0] v);
    if (v == '0) return 1;
    if (v > COUNT_W'(MAX_VERTICES)) return MAX_VERTICES;
    return int'(v);
  endfunction

  // Advance the coloring state by one accepted item; queue the row result on row_last.
  task automatic predict_item(input item_t it);
    int      cnt;
    int      c;
    logic    finished;
    result_t r;
    cnt = clamp_count(vcount_reg);
    // First item of a row: pick the lowest color clear in the vertex's own mask.
    if (!row_open) begin
      cur_color = COLOR_W'(MAX_COLORS - 1);
      row_ovf   = 1'b1;
      for (c = 0; c < MAX_COLORS; c++) begin
        if (row_ovf && !forbid_mask[vtx_ctr][c]) begin
          cur_color = COLOR_W'(c);
          row_ovf   = 1'b0;
        end
      end
      row_err  = 1'b0;
      row_open = 1'b1;
    end
    // Forbid the color on an in-range neighbor; flag the row otherwise.
    if (it.has_neighbor) begin
      if (int'(it.neighbor) < cnt) forbid_mask[it.neighbor][cur_color] = 1'b1;
      else row_err = 1'b1;
    end
    if (it.row_last) begin
      finished         = (vtx_ctr >= cnt - 1);
      r.vertex         = VIDX_W'(vtx_ctr);
      r.color          = cur_color;
      r.color_overflow = row_ovf;
      r.index_error    = row_err;
      r.matrix_done    = finished;
      color_expect_q.push_back(r);
      row_open = 1'b0;
      row_err  = 1'b0;
      row_ovf  = 1'b0;
      // Final vertex: wipe the store and restart at vertex 0.
      if (finished) begin
        foreach (forbid_mask[i]) forbid_mask[i] = '0;
        vtx_ctr = 0;
      end else begin
        vtx_ctr++;
      end
    end
  endtask

  // Monitor: check popped results, predict accepted items, track config and stalls.
  always @(posedge clk) begin : monitor
    result_t want;
    logic    moved;
    if (rst) begin
      foreach (forbid_mask[i]) forbid_mask[i] = '0;
      vtx_ctr      = 0;
      cur_color    = '0;
      row_open     = 1'b0;
      row_err      = 1'b0;
      row_ovf      = 1'b0;
      vcount_reg   = COUNT_W'(MAX_VERTICES);
      stall_cycles = 0;
    end else begin
      moved = 1'b0;
      // Compare first, so a result that shows up with nothing queued is caught.
      if (pop && !empty) begin
        moved = 1'b1;
        if (color_expect_q.size() == 0) begin
          $error("unexpected result: vertex %0d color %0d", result.vertex, result.color);
          fail_count++;
        end else begin
          want = color_expect_q.pop_front();
          if (result.vertex !== want.vertex) begin
            $error("vertex: expected %0d, got %0d", want.vertex, result.vertex);
            fail_count++;
          end
          if (result.color !== want.color) begin
            $error("color: expected %0d, got %0d", want.color, result.color);
            fail_count++;
          end
          if (result.color_overflow !== want.color_overflow) begin
            $error("color_overflow: expected %0b, got %0b",
                   want.color_overflow, result.color_overflow);
            fail_count++;
          end
          if (result.index_error !== want.index_error) begin
            $error("index_error: expected %0b, got %0b", want.index_error, result.index_error);
            fail_count++;
          end
          if (result.matrix_done !== want.matrix_done) begin
            $error("matrix_done: expected %0b, got %0b", want.matrix_done, result.matrix_done);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        predict_item(item);
      end
      if (cfg_valid && cfg_ready) begin
        moved      = 1'b1;
        vcount_reg = cfg_data;
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test requests one.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      pop       <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one item and hold it until the core takes the transaction.
  // Leave push high so back-to-back items stream without a bubble.
  task automatic send_item(input logic [VIDX_W-1:0] nb, input logic has_nb,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= {nb, has_nb, last};
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push and wait until every predicted result has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (color_expect_q.size() != 0) @(posedge clk);
  endtask

  // Write vertex_count once the core is quiet, clearing pass included.
  task automatic write_vertex_count(input logic [COUNT_W-1:0] v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_count = clamp_count(v);
  endtask

  // One random row: mostly in-range neighbors, some out of range, absorbed
  // no-neighbor items sprinkled in, sometimes closed by a no-neighbor item.
  task automatic send_random_row(inout int sent);
    int                len;
    int                k;
    logic [VIDX_W-1:0] nb;
    len = ($urandom_range(15) == 0) ? $urandom_range(20, 6) : $urandom_range(5, 0);
    if (len == 0) begin
      send_item(VIDX_W'($urandom), 1'b0, 1'b1);
      sent++;
    end
    for (k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_item(VIDX_W'($urandom), 1'b0, 1'b0);
      if ($urandom_range(99) < 10 && cur_count < MAX_VERTICES)
        nb = VIDX_W'($urandom_range(MAX_VERTICES - 1, cur_count));
      else
        nb = VIDX_W'($urandom_range(cur_count - 1, 0));
      if (k == len - 1 && $urandom_range(7) == 0) begin
        send_item(nb, 1'b1, 1'b0);
        send_item(VIDX_W'($urandom), 1'b0, 1'b1);
        sent += 2;
      end else begin
        send_item(nb, 1'b1, k == len - 1);
        sent++;
      end
    end
  endtask

  // Reset value of vertex_count is 1024: neighbor 1023 must be in range.
  task automatic test_reset_default();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(10'h3FF, 1'b1, 1'b0);
    send_item(10'd1, 1'b1, 1'b1);
    send_item(10'd0, 1'b1, 1'b1);
    send_item(10'h200, 1'b0, 1'b0);
    send_item(10'h3FF, 1'b0, 1'b1);
  endtask

  // Corner rows: mid-pattern shrink, out-of-range and self neighbors, empty
  // rows, absorbed items, and register values outside 1..1024.
  task automatic test_directed_edges();
    // Counter sits at 3, so shrinking to 4 makes the next row the last one.
    write_vertex_count(11'd4);
    send_item(10'd2, 1'b1, 1'b0);
    send_item(10'd4, 1'b1, 1'b1);
    send_item(10'd0, 1'b1, 1'b0);
    send_item(10'h3FF, 1'b1, 1'b1);
    send_item(10'd0, 1'b0, 1'b1);
    send_item(10'd3, 1'b1, 1'b1);
    send_item(10'd1, 1'b0, 1'b0);
    send_item(10'd2, 1'b1, 1'b1);
    // Zero acts as one: every row closes the pattern.
    write_vertex_count(11'd0);
    send_item(10'd0, 1'b1, 1'b1);
    send_item(10'd1, 1'b1, 1'b1);
    // All ones acts as 1024.
    write_vertex_count(11'h7FF);
    send_item(10'h3FF, 1'b1, 1'b1);
    send_item(10'd0, 1'b1, 1'b1);
  endtask

  // A 65-vertex clique: vertex i takes color i, vertex 64 finds all colors gone.
  task automatic test_color_overflow();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    // Close the open pattern so the clique starts at vertex 0.
    write_vertex_count(11'd1);
    send_item(10'd0, 1'b0, 1'b1);
    write_vertex_count(11'd65);
    for (int j = 0; j < 64; j++) begin
      for (int k = j + 1; k <= 64; k++) send_item(VIDX_W'(k), 1'b1, k == 64);
    end
    send_item(10'd0, 1'b1, 1'b1);
  endtask

  // Random rows under one register setting and one traffic profile.
  task automatic test_random_phase(input logic [COUNT_W-1:0] count, input int n_items,
                                   input int send_pct, input int recv_pct);
    int sent;
    sent = 0;
    write_vertex_count(count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (sent < n_items) send_random_row(sent);
  endtask

  // Hold pop low for a long stretch while items keep coming, so both
  // queues fill and full pushes back on the sender.
  task automatic test_result_backpressure();
    int sent;
    sent = 0;
    write_vertex_count(11'd30);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    while (sent < 120) send_random_row(sent);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_directed_edges();
    test_color_overflow();
    test_random_phase(11'd0,    60,  0,  0);
    test_random_phase(11'd1,    60, 55,  0);
    test_random_phase(11'h7FF, 150,  0, 55);
    test_random_phase(11'd1025, 100, 8,  8);
    test_random_phase(11'd2,   120,  0,  0);
    test_random_phase(11'd5,   150, 55,  0);
    test_random_phase(11'd17,  150,  0, 55);
    test_random_phase(11'd40,  150,  8,  8);
    test_result_backpressure();
    test_random_phase(COUNT_W'($urandom_range(64, 1)),   150,  0,  0);
    test_random_phase(COUNT_W'($urandom_range(1024, 1)), 100, 55,  0);

    // Let the last transactions and any clearing pass run out.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
